[rtl/ps2_mouse_packet_cursor_tracker_core_assert.svh]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Shared concurrent assertion wrappers for the tracker checker.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH

// Assertion on an explicit clock and active-low reset
`define PS2MCT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset
`define PS2MCT_ASSERT(lbl, prop, msg) \
  `PS2MCT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/ps2mct_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker package
// Constants, register codes and the packet struct shared by the tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int POSITION_BITS_DEF = 12;
  localparam int CFG_W             = 13;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WHEEL  = 2'd2;

  localparam int         SYNC_BIT  = 3;
  localparam int         XSIGN_BIT = 4;
  localparam int         YSIGN_BIT = 5;
  localparam logic [7:0] OVF_MASK  = 8'hC0;

  typedef struct packed {
    logic              valid;    // complete packet, no overflow
    logic [2:0]        buttons;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic signed [4:0] dz;
  } pkt_t;

  // size as clamped by the cursor logic: zero is one, large saturates
  function automatic int eff_size(int v, int pb);
    int lim;
    lim = 1 << pb;
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

endpackage

[rtl/ps2mct_framer.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker packet framer
// Byte sync, packet assembly and movement field extraction.
// ----------------------------------------------------------------------------
module ps2mct_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              wheel_mode_i,
  output ps2mct_pkg::pkt_t  pkt_o
);

  logic [1:0] pos_q, pos_d;
  logic [7:0] pb_q [0:2];
  logic       wr_en;
  logic       complete;
  logic [1:0] last;
  logic [7:0] hdr;
  logic [7:0] dy_byte;
  logic signed [4:0] nib_s;

  always_comb begin
    last     = wheel_mode_i ? 2'd3 : 2'd2;
    pos_d    = pos_q;
    wr_en    = 1'b0;
    complete = 1'b0;
    if (fire_i) begin
      if (pos_q == 2'd0 && !byte_i[ps2mct_pkg::SYNC_BIT]) begin
        pos_d = pos_q;                 // out of sync, drop
      end else if (pos_q < last) begin
        wr_en = 1'b1;
        pos_d = pos_q + 2'd1;
      end else begin
        pos_d    = 2'd0;
        complete = 1'b1;
      end
    end
  end

  always_comb begin
    hdr     = pb_q[0];
    dy_byte = (pos_q == 2'd2) ? byte_i : pb_q[2];
    nib_s   = {byte_i[3], byte_i[3:0]};
    pkt_o.valid   = complete && ((hdr & ps2mct_pkg::OVF_MASK) == 8'h00);
    pkt_o.buttons = hdr[2:0];
    pkt_o.dx      = {hdr[ps2mct_pkg::XSIGN_BIT], pb_q[1]};
    pkt_o.dy      = {hdr[ps2mct_pkg::YSIGN_BIT], dy_byte};
    pkt_o.dz      = (pos_q == 2'd3 && wheel_mode_i) ? -nib_s : 5'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pb_q[pos_q] <= byte_i;
    end
  end

endmodule

[rtl/ps2mct_cursor.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker cursor unit
// Cursor position state, movement and clamping to the screen.
// ----------------------------------------------------------------------------
module ps2mct_cursor #(
  parameter int POSITION_BITS = ps2mct_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ps2mct_pkg::pkt_t                   pkt_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]       width_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]       height_i,
  output logic [POSITION_BITS-1:0]           col_o,
  output logic [POSITION_BITS-1:0]           row_o
);

  localparam int SIZE_W = POSITION_BITS + 1;
  localparam int SUM_W  = POSITION_BITS + 2;
  localparam logic [31:0] LIMIT32 = 32'd1 << POSITION_BITS;
  localparam int RST_COL =
    ps2mct_pkg::eff_size(int'(ps2mct_pkg::RST_WIDTH), POSITION_BITS) / 2;
  localparam int RST_ROW =
    ps2mct_pkg::eff_size(int'(ps2mct_pkg::RST_HEIGHT), POSITION_BITS) / 2;

  function automatic logic [SIZE_W-1:0] eff(input logic [ps2mct_pkg::CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v == '0) return SIZE_W'(1);
    if (v32 > LIMIT32) return SIZE_W'(LIMIT32);
    return SIZE_W'(v);
  endfunction

  function automatic logic [POSITION_BITS-1:0] clamp(input logic signed [SUM_W-1:0] p,
                                                     input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] top;
    top = size - SIZE_W'(1);
    if (p[SUM_W-1]) return '0;
    if (p >= $signed({1'b0, size})) return POSITION_BITS'(top);
    return POSITION_BITS'(p);
  endfunction

  logic [POSITION_BITS-1:0] col_q, row_q;
  logic signed [SUM_W-1:0]  dx_ext, dy_ext, sum_x, sum_y;

  always_comb begin
    dx_ext = SUM_W'(pkt_i.dx);
    dy_ext = SUM_W'(pkt_i.dy);
    // Y on the mouse runs upward, the screen row downward
    sum_x  = $signed({2'b00, col_q}) + dx_ext;
    sum_y  = $signed({2'b00, row_q}) - dy_ext;
    col_o  = clamp(sum_x, eff(width_i));
    row_o  = clamp(sum_y, eff(height_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= POSITION_BITS'(RST_COL);
      row_q <= POSITION_BITS'(RST_ROW);
    end else if (pkt_i.valid) begin
      col_q <= col_o;
      row_q <= row_o;
    end
  end

endmodule

[rtl/ps2_mouse_packet_cursor_tracker_core.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Assembles PS/2 mouse packets and tracks a clamped screen cursor.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   data_byte_i
// out       out  out_valid_o/out_ready_i cursor_x_o, cursor_y_o, buttons_o,
//                                        wheel_delta_o
// cfg       in   APB psel/penable        paddr, pwdata, prdata (pready high)
//
// One item per cycle sustained while no result stalls. A byte enters the
// input register when accepted; its result is loaded into the result register
// once the slot is free. The cursor add and clamp between them sets the cycle.
// Reset clears byte sync, centres the cursor, loads 640 x 480, three-byte mode.
// A stalled result holds the byte behind it; in_ready_o falls only while both
// registers are full and out_ready_i is low.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int POSITION_BITS = ps2mct_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // byte input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [POSITION_BITS-1:0] cursor_x_o,
  output logic [POSITION_BITS-1:0] cursor_y_o,
  output logic [2:0]               buttons_o,
  output logic signed [4:0]        wheel_delta_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CW = ps2mct_pkg::CFG_W;

  // configuration registers
  logic [CW-1:0] width_q, height_q;
  logic          wheel_q;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2mct_pkg::RST_WIDTH;
      height_q <= ps2mct_pkg::RST_HEIGHT;
      wheel_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ps2mct_pkg::REG_WIDTH:  width_q  <= pwdata[CW-1:0];
        ps2mct_pkg::REG_HEIGHT: height_q <= pwdata[CW-1:0];
        ps2mct_pkg::REG_WHEEL:  wheel_q  <= pwdata[0];
        default: ;              // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ps2mct_pkg::REG_WIDTH:  prdata = {{(32-CW){1'b0}}, width_q};
      ps2mct_pkg::REG_HEIGHT: prdata = {{(32-CW){1'b0}}, height_q};
      ps2mct_pkg::REG_WHEEL:  prdata = {31'd0, wheel_q};
      default:                prdata = 32'd0;
    endcase
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       proc_fire;
  logic       out_valid_q;

  // the byte in the input register is consumed once the result slot is free
  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // framer and cursor
  ps2mct_pkg::pkt_t         pkt;
  logic [POSITION_BITS-1:0] col_d, row_d;

  ps2mct_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (proc_fire),
    .byte_i       (in_byte_q),
    .wheel_mode_i (wheel_q),
    .pkt_o        (pkt)
  );

  ps2mct_cursor #(
    .POSITION_BITS (POSITION_BITS)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pkt_i    (pkt),
    .width_i  (width_q),
    .height_i (height_q),
    .col_o    (col_d),
    .row_o    (row_d)
  );

  // result register
  logic                     out_valid_d;
  logic [POSITION_BITS-1:0] x_q, y_q;
  logic [2:0]               btn_q;
  logic signed [4:0]        dz_q;

  assign out_valid_d = (out_valid_q && !out_ready_i) || pkt.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt.valid) begin
      x_q   <= col_d;
      y_q   <= row_d;
      btn_q <= pkt.buttons;
      dz_q  <= pkt.dz;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = x_q;
  assign cursor_y_o    = y_q;
  assign buttons_o     = btn_q;
  assign wheel_delta_o = dz_q;

endmodule

[rtl/ps2mct_checker.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker checker
// Port-level assertions on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_core_assert.svh"

module ps2mct_checker #(
  parameter int POSITION_BITS = ps2mct_pkg::POSITION_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [POSITION_BITS-1:0] cursor_x_o,
  input logic [POSITION_BITS-1:0] cursor_y_o,
  input logic [2:0]               buttons_o,
  input logic signed [4:0]        wheel_delta_o
);

  // a stalled result keeps its slot and its payload
  `PS2MCT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable({cursor_x_o, cursor_y_o, buttons_o, wheel_delta_o}), "result changed while stalled")

  // negated nibble never leaves -7..8
  `PS2MCT_ASSERT(a_wheel_range, out_valid_o |-> (wheel_delta_o >= -5'sd7) && (wheel_delta_o <= 5'sd8), "wheel delta out of range")

  // a new result is loaded from a byte held in the input register, so a rising
  // out_valid_o has an accepted byte behind it
  `PS2MCT_ASSERT(a_result_cause, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without a byte behind it")

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2mct_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_checker (.*);
